// ----- design/bpdd_pkg.sv -----
// Package for the base-p digit dominance block.
// Default widths, fixed port widths and register reset values.
// No dependencies.
package bpdd_pkg;

	localparam int VALUE_BITS_DEF = 64;
	localparam int BASE_BITS_DEF  = 16;

	// Width of the position result port.
	localparam int POS_BITS = 6;

	// Radix register reset value; the scan raises smaller radix values to BASE_MIN.
	localparam int BASE_RESET = 2;
	localparam int BASE_MIN   = 2;

endpackage

// ----- design/base_p_digit_dominance.sv -----
// Top level of the base-p digit dominance block: radix register, scan, divider, output register.
// Depends on bpdd_pkg, bpdd_scan and bpdd_divider.
//
// channel | direction | handshake             | payload
// cfg     | in        | cfg_valid / cfg_ready | digit_base
// in      | in        | in_valid / in_ready   | candidate, limit
// out     | out       | out_valid / out_ready | exceeds, no_position, position, gap,
//         |           |                       | next_candidate
//
// Requests are taken one at a time. Per request the scan runs the shared bit-serial
// divider, one quotient bit per cycle, once for each base-p digit scanned (up to
// VALUE_BITS digits) and once more when a position is found; the divider width is
// the max of VALUE_BITS and BASE_BITS. in_ready is high only while idle.
// Reset (arst_n low) sets the radix to 2 and empties the scan and the output register.
// A result waits in the output register while the scan already takes the next request.
module base_p_digit_dominance #(
	parameter int VALUE_BITS = bpdd_pkg::VALUE_BITS_DEF,
	parameter int BASE_BITS  = bpdd_pkg::BASE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [BASE_BITS-1:0]          digit_base,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [VALUE_BITS-1:0]         candidate,
	input  logic [VALUE_BITS-1:0]         limit,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          exceeds,
	output logic                          no_position,
	output logic [bpdd_pkg::POS_BITS-1:0] position,
	output logic [VALUE_BITS-1:0]         gap,
	output logic [VALUE_BITS-1:0]         next_candidate
);

	// Divider width covers both the values and any radix the register can hold.
	localparam int DW = (VALUE_BITS > BASE_BITS) ? VALUE_BITS : BASE_BITS;

	logic [BASE_BITS-1:0]            base_q;
	logic                            out_valid_q;
	logic                            exceeds_q;
	logic                            no_position_q;
	logic [bpdd_pkg::POS_BITS-1:0]   position_q;
	logic [VALUE_BITS-1:0]           gap_q;
	logic [VALUE_BITS-1:0]           next_q;

	logic                            div_start;
	logic [DW-1:0]                   div_divisor;
	logic [DW-1:0]                   div_dividend_a;
	logic [DW-1:0]                   div_dividend_b;
	logic                            div_done;
	logic [DW-1:0]                   div_quo_a;
	logic [DW-1:0]                   div_quo_b;
	logic [DW-1:0]                   div_rem_a;
	logic [DW-1:0]                   div_rem_b;

	logic                            res_valid;
	logic                            res_take;
	logic                            res_exceeds;
	logic                            res_no_position;
	logic [bpdd_pkg::POS_BITS-1:0]   res_position;
	logic [VALUE_BITS-1:0]           res_gap;
	logic [VALUE_BITS-1:0]           res_next;

	// Radix register: the user must write it only while idle; the block does not enforce this, so always ready.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_BITS'(bpdd_pkg::BASE_RESET);
		end else if (cfg_valid) begin
			base_q <= digit_base;
		end
	end

	bpdd_scan #(
		.VALUE_BITS(VALUE_BITS),
		.BASE_BITS (BASE_BITS),
		.DW        (DW)
	) u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.base           (base_q),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.candidate      (candidate),
		.limit          (limit),
		.div_start      (div_start),
		.div_divisor    (div_divisor),
		.div_dividend_a (div_dividend_a),
		.div_dividend_b (div_dividend_b),
		.div_done       (div_done),
		.div_quo_a      (div_quo_a),
		.div_quo_b      (div_quo_b),
		.div_rem_a      (div_rem_a),
		.div_rem_b      (div_rem_b),
		.res_valid      (res_valid),
		.res_take       (res_take),
		.res_exceeds    (res_exceeds),
		.res_no_position(res_no_position),
		.res_position   (res_position),
		.res_gap        (res_gap),
		.res_next       (res_next)
	);

	bpdd_divider #(
		.W(DW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.divisor   (div_divisor),
		.dividend_a(div_dividend_a),
		.dividend_b(div_dividend_b),
		.done      (div_done),
		.quo_a     (div_quo_a),
		.quo_b     (div_quo_b),
		.rem_a     (div_rem_a),
		.rem_b     (div_rem_b)
	);

	// Output register: take the scan result when empty or being drained.
	assign res_take = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			exceeds_q     <= res_exceeds;
			no_position_q <= res_no_position;
			position_q    <= res_position;
			gap_q         <= res_gap;
			next_q        <= res_next;
		end
	end

	assign out_valid      = out_valid_q;
	assign exceeds        = exceeds_q;
	assign no_position    = no_position_q;
	assign position       = position_q;
	assign gap            = gap_q;
	assign next_candidate = next_q;

endmodule

// ----- design/bpdd_divider.sv -----
// Shared restoring divider for the base-p digit dominance block.
// Two dividends over one common divisor, one quotient bit per cycle.
// Depends on nothing but its parameter.
module bpdd_divider #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] divisor,
	input  logic [W-1:0] dividend_a,
	input  logic [W-1:0] dividend_b,
	output logic         done,
	output logic [W-1:0] quo_a,
	output logic [W-1:0] quo_b,
	output logic [W-1:0] rem_a,
	output logic [W-1:0] rem_b
);

	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  div_q;
	logic [W-1:0]  qa_q;
	logic [W-1:0]  qb_q;
	logic [W-1:0]  ra_q;
	logic [W-1:0]  rb_q;
	logic [W:0]    step_a;
	logic [W:0]    step_b;

	// One restoring step: returns {new remainder, quotient bit}.
	function automatic logic [W:0] div_step(input logic [W-1:0] rem, input logic msb,
			input logic [W-1:0] dv);
		logic [W:0]   shifted;
		logic [W+1:0] diff;
		shifted = {rem, msb};
		diff    = {1'b0, shifted} - {2'b00, dv};
		if (diff[W+1]) begin
			div_step = {shifted[W-1:0], 1'b0};
		end else begin
			div_step = {diff[W-1:0], 1'b1};
		end
	endfunction

	assign step_a = div_step(ra_q, qa_q[W-1], div_q);
	assign step_b = div_step(rb_q, qb_q[W-1], div_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			qa_q  <= dividend_a;
			qb_q  <= dividend_b;
			ra_q  <= '0;
			rb_q  <= '0;
		end else if (busy_q) begin
			ra_q <= step_a[W:1];
			rb_q <= step_b[W:1];
			qa_q <= {qa_q[W-2:0], step_a[0]};
			qb_q <= {qb_q[W-2:0], step_b[0]};
		end
	end

	assign done  = done_q;
	assign quo_a = qa_q;
	assign quo_b = qb_q;
	assign rem_a = ra_q;
	assign rem_b = rb_q;

endmodule

// ----- design/bpdd_scan.sv -----
// Digit scan sequencer for the base-p digit dominance block.
// Drives the shared divider per digit, tracks p^k, then forms gap and next value.
// Depends on bpdd_pkg.
module bpdd_scan #(
	parameter int VALUE_BITS = bpdd_pkg::VALUE_BITS_DEF,
	parameter int BASE_BITS  = bpdd_pkg::BASE_BITS_DEF,
	parameter int DW         = (VALUE_BITS > BASE_BITS) ? VALUE_BITS : BASE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [BASE_BITS-1:0]         base,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [VALUE_BITS-1:0]        candidate,
	input  logic [VALUE_BITS-1:0]        limit,
	output logic                         div_start,
	output logic [DW-1:0]                div_divisor,
	output logic [DW-1:0]                div_dividend_a,
	output logic [DW-1:0]                div_dividend_b,
	input  logic                         div_done,
	input  logic [DW-1:0]                div_quo_a,
	input  logic [DW-1:0]                div_quo_b,
	input  logic [DW-1:0]                div_rem_a,
	input  logic [DW-1:0]                div_rem_b,
	output logic                         res_valid,
	input  logic                         res_take,
	output logic                         res_exceeds,
	output logic                         res_no_position,
	output logic [bpdd_pkg::POS_BITS-1:0] res_position,
	output logic [VALUE_BITS-1:0]        res_gap,
	output logic [VALUE_BITS-1:0]        res_next
);

	localparam int KW = $clog2(VALUE_BITS) + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_DIV,
		S_FINAL,
		S_SUM,
		S_DONE
	} state_t;

	state_t                          state_q;
	logic [BASE_BITS-1:0]            p_q;
	logic [VALUE_BITS-1:0]           cand_q;
	logic [VALUE_BITS-1:0]           lim_q;
	logic [DW-1:0]                   a_q;
	logic [DW-1:0]                   b_q;
	logic [VALUE_BITS-1:0]           pk_q;
	logic [KW-1:0]                   k_q;
	logic                            exc_q;
	logic                            found_q;
	logic [VALUE_BITS-1:0]           gap_q;
	logic [VALUE_BITS-1:0]           next_q;
	logic [VALUE_BITS-1:0]           mul_acc_q;
	logic [VALUE_BITS-1:0]           mul_x_q;
	logic [BASE_BITS-1:0]            mul_y_q;
	logic                            digits_left;
	logic                            in_take;
	logic                            dig_gt;
	logic                            dig_lt;

	assign in_ready    = (state_q == S_IDLE);
	assign in_take     = in_ready && in_valid;
	assign digits_left = (a_q != '0) || (b_q != '0);
	assign dig_gt      = div_rem_a > div_rem_b;
	assign dig_lt      = div_rem_a < div_rem_b;

	// Per digit: divide both values by p; at the end, if a position was found: candidate by p^k.
	assign div_start      = (state_q == S_CHECK) && (digits_left || found_q);
	assign div_divisor    = digits_left ? DW'(p_q) : DW'(pk_q);
	assign div_dividend_a = digits_left ? a_q : DW'(cand_q);
	assign div_dividend_b = b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (digits_left) state_q <= S_DIV;
					else if (found_q) state_q <= S_FINAL;
					else state_q <= S_DONE;
				end
				S_DIV: begin
					if (div_done) state_q <= S_CHECK;
				end
				S_FINAL: begin
					if (div_done) state_q <= S_SUM;
				end
				S_SUM: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			p_q     <= (base < BASE_BITS'(bpdd_pkg::BASE_MIN)) ?
				BASE_BITS'(bpdd_pkg::BASE_MIN) : base;
			cand_q  <= candidate;
			lim_q   <= limit;
			a_q     <= DW'(candidate);
			b_q     <= DW'(limit);
			pk_q    <= VALUE_BITS'(1);
			k_q     <= '0;
			exc_q   <= 1'b0;
			found_q <= 1'b0;
		end
		// p^k * p by shift-add, one radix bit per divider cycle; DW >= BASE_BITS,
		// so the product is complete before the division ends.
		if (div_start && digits_left) begin
			mul_acc_q <= '0;
			mul_x_q   <= pk_q;
			mul_y_q   <= p_q;
		end else if (state_q == S_DIV) begin
			if (mul_y_q[0]) mul_acc_q <= mul_acc_q + mul_x_q;
			mul_x_q <= mul_x_q << 1;
			mul_y_q <= mul_y_q >> 1;
		end
		if (state_q == S_CHECK && !digits_left && !found_q) begin
			gap_q  <= '0;
			next_q <= lim_q;
		end
		if (state_q == S_DIV && div_done) begin
			a_q   <= div_quo_a;
			b_q   <= div_quo_b;
			exc_q <= exc_q | dig_gt;
			if (!found_q) begin
				if (dig_lt) begin
					found_q <= 1'b1;
				end else begin
					// p^k past the last position may wrap; never used then
					pk_q <= mul_acc_q;
					k_q  <= k_q + KW'(1);
				end
			end
		end
		if (state_q == S_FINAL && div_done) begin
			gap_q <= pk_q - div_rem_a[VALUE_BITS-1:0];
		end
		if (state_q == S_SUM) begin
			next_q <= cand_q + gap_q;
		end
	end

	assign res_valid       = (state_q == S_DONE);
	assign res_exceeds     = exc_q;
	assign res_no_position = !found_q;
	assign res_position    = found_q ? bpdd_pkg::POS_BITS'(k_q) : '0;
	assign res_gap         = gap_q;
	assign res_next        = next_q;

endmodule

// ----- design/bpdd_checker.sv -----
// Port-level checks for the base-p digit dominance block, bound to its top level.
// Depends on bpdd_pkg and base_p_digit_dominance.
module bpdd_checker #(
	parameter int VALUE_BITS = bpdd_pkg::VALUE_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          exceeds,
	input logic                          no_position,
	input logic [bpdd_pkg::POS_BITS-1:0] position,
	input logic [VALUE_BITS-1:0]         gap,
	input logic [VALUE_BITS-1:0]         next_candidate
);

	// One request at a time: busy right after a request is taken.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready high in the cycle after a request was taken");

	// Held result stays put until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(exceeds) &&
		$stable(no_position) && $stable(position) && $stable(gap) &&
		$stable(next_candidate)))
		else $error("result changed or dropped while stalled");

	// No position: position and gap read zero.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && no_position) |-> (position == '0 && gap == '0))
		else $error("nonzero position or gap with no position");

	// Found position: gap is p^k minus a smaller remainder, never zero.
	a_gap_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !no_position) |-> (gap != '0))
		else $error("zero gap with a position found");

endmodule

bind base_p_digit_dominance bpdd_checker #(
	.VALUE_BITS(VALUE_BITS)
) u_bpdd_checker (.*);
